// ===== src/hpru_pkg.sv =====
// ----------------------------------------------------------------------------
// hpru_pkg
// Types, constants and helpers for the hit point radiance update block.
// ----------------------------------------------------------------------------
package hpru_pkg;

	localparam int HIT_POINTS_DEF = 4096;

	localparam int IDX_W   = 12;
	localparam int COL_W   = 32;
	localparam int PT_W    = 40;
	localparam int R2_W    = 32;
	localparam int SUM_W   = 40;
	localparam int CNT_W   = 32;
	localparam int ALPHA_W = 16;
	localparam int MODE_W  = 2;
	localparam int ALU_W   = 128;
	localparam int CFG_AW  = 6;
	localparam int CFG_DW  = 64;

	localparam logic [33:0] PI_Q32 = 34'd13493037705;

	localparam logic [2:0] REG_MODE      = 3'd0;
	localparam logic [2:0] REG_ALPHA     = 3'd1;
	localparam logic [2:0] REG_PHOTONS   = 3'd2;
	localparam logic [2:0] REG_SHARED_R2 = 3'd3;
	localparam logic [2:0] REG_INIT_R2   = 3'd4;

	localparam logic [MODE_W-1:0]  MODE_RST    = 2'd0;
	localparam logic [ALPHA_W-1:0] ALPHA_RST   = 16'd45875;
	localparam logic [PT_W-1:0]    PHOTONS_RST = 40'd1;
	localparam logic [R2_W-1:0]    R2_RST      = 32'd16777216;

	localparam logic KIND_INIT = 1'b1;

	typedef struct packed {
		logic             kind;
		logic [IDX_W-1:0] entry_index;
		logic             is_surface;
		logic [COL_W-1:0] throughput_red;
		logic [COL_W-1:0] throughput_green;
		logic [COL_W-1:0] throughput_blue;
		logic [CNT_W-1:0] new_photons;
		logic [COL_W-1:0] new_flux_red;
		logic [COL_W-1:0] new_flux_green;
		logic [COL_W-1:0] new_flux_blue;
	} item_t;

	typedef struct packed {
		logic [COL_W-1:0] radiance_red;
		logic [COL_W-1:0] radiance_green;
		logic [COL_W-1:0] radiance_blue;
		logic [R2_W-1:0]  radius2_now;
	} result_t;

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [ALPHA_W-1:0] alpha;
		logic [PT_W-1:0]    photons;
		logic [R2_W-1:0]    shared_r2;
		logic [R2_W-1:0]    init_r2;
	} cfg_t;

	typedef enum logic [2:0] {
		OP_SKIP,
		OP_INIT,
		OP_PPM_CONST,
		OP_PPM_SURF,
		OP_PPM_SHARED,
		OP_SPPM_CONST,
		OP_SPPM_SURF
	} op_t;

	typedef struct packed {
		op_t                   op;
		logic                  shared;
		logic [IDX_W-1:0]      index;
		logic [2:0][COL_W-1:0] tp;
		logic [CNT_W-1:0]      m;
		logic [2:0][COL_W-1:0] nf;
	} task_t;

	typedef struct packed {
		logic [PT_W-1:0]       photon_total;
		logic [2:0][COL_W-1:0] flux;
		logic [R2_W-1:0]       radius2;
		logic [2:0][SUM_W-1:0] summed;
		logic [CNT_W-1:0]      const_hits;
		logic [CNT_W-1:0]      surf_hits;
		logic [2:0][COL_W-1:0] last;
	} entry_t;

	typedef enum logic {
		ALU_MUL,
		ALU_DIV
	} alu_op_t;

	typedef struct packed {
		logic             start;
		alu_op_t          op;
		logic [ALU_W-1:0] a;
		logic [ALU_W-1:0] b;
	} alu_req_t;

	typedef struct packed {
		logic             done;
		logic [ALU_W-1:0] res;
	} alu_rsp_t;

	function automatic logic [31:0] sat32(input logic [ALU_W-1:0] v);
		sat32 = (v[ALU_W-1:32] != '0) ? '1 : v[31:0];
	endfunction

	function automatic logic [PT_W-1:0] sat40(input logic [PT_W:0] v);
		sat40 = v[PT_W] ? '1 : v[PT_W-1:0];
	endfunction

endpackage

// ===== src/hpru_ifs.sv =====
// ----------------------------------------------------------------------------
// hpru channel interfaces
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface hpru_item_if import hpru_pkg::*; ();
	logic  valid;
	logic  ready;
	item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface hpru_result_if import hpru_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== src/hpru_ram.sv =====
// ----------------------------------------------------------------------------
// hpru_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module hpru_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/hpru_alu.sv =====
// ----------------------------------------------------------------------------
// hpru_alu
// Shared bit-serial unit: shift-add multiply and restoring divide.
// ----------------------------------------------------------------------------
module hpru_alu import hpru_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  alu_req_t req,
	output alu_rsp_t rsp
);

	localparam int CW = $clog2(ALU_W);

	logic             busy_q;
	logic             done_q;
	alu_op_t          op_q;
	logic [ALU_W-1:0] acc_q;
	logic [ALU_W-1:0] x_q;
	logic [ALU_W-1:0] y_q;
	logic [ALU_W-1:0] r_q;
	logic [ALU_W-1:0] res_q;
	logic [CW-1:0]    cnt_q;

	logic [ALU_W:0]   rs;
	logic [ALU_W:0]   rdiff;
	logic             ge;
	logic [ALU_W-1:0] qn;

	assign rs    = {r_q, x_q[ALU_W-1]};
	assign ge    = rs >= {1'b0, y_q};
	assign rdiff = rs - {1'b0, y_q};
	assign qn    = {acc_q[ALU_W-2:0], ge};

	assign rsp.done = done_q;
	assign rsp.res  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (!busy_q) begin
				if (req.start) begin
					busy_q <= 1'b1;
					op_q   <= req.op;
					acc_q  <= '0;
					x_q    <= req.a;
					y_q    <= req.b;
					r_q    <= '0;
					cnt_q  <= CW'(ALU_W - 1);
					if (req.op == ALU_DIV && req.b == '0) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
						res_q  <= '1;
					end
				end
			end else begin
				unique case (op_q)
					ALU_MUL: begin
						if (y_q == '0) begin
							busy_q <= 1'b0;
							done_q <= 1'b1;
							res_q  <= acc_q;
						end else begin
							if (y_q[0]) begin
								acc_q <= acc_q + x_q;
							end
							x_q <= x_q << 1;
							y_q <= y_q >> 1;
						end
					end
					ALU_DIV: begin
						r_q   <= ge ? rdiff[ALU_W-1:0] : rs[ALU_W-1:0];
						acc_q <= qn;
						x_q   <= x_q << 1;
						if (cnt_q == '0) begin
							busy_q <= 1'b0;
							done_q <= 1'b1;
							res_q  <= qn;
						end else begin
							cnt_q <= cnt_q - CW'(1);
						end
					end
				endcase
			end
		end
	end

endmodule

// ===== src/hpru_front.sv =====
// ----------------------------------------------------------------------------
// hpru_front
// Accepts input words, classifies them by mode and kind, queues the tasks.
// ----------------------------------------------------------------------------
module hpru_front import hpru_pkg::*; #(
	parameter int HIT_POINTS = HIT_POINTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	hpru_item_if.sink         items,
	input  logic [MODE_W-1:0] mode,
	output logic              q_valid,
	output task_t             q_task,
	input  logic              q_pop
);

	localparam int QD = 2;
	localparam int PW = $clog2(QD);
	localparam int CW = $clog2(QD + 1);

	task_t         fifo_q [QD];
	logic [PW-1:0] wp_q;
	logic [PW-1:0] rp_q;
	logic [CW-1:0] cnt_q;
	task_t         tk;
	logic          push;
	logic          pop;
	logic          in_range;
	logic          shared;
	logic          sppm;

	assign shared   = mode[0];
	assign sppm     = mode[1];
	assign in_range = 32'(items.data.entry_index) < 32'(HIT_POINTS);

	always_comb begin
		tk.shared = shared;
		tk.index  = items.data.entry_index;
		tk.tp     = {items.data.throughput_blue, items.data.throughput_green,
			items.data.throughput_red};
		tk.m      = items.data.new_photons;
		tk.nf     = {items.data.new_flux_blue, items.data.new_flux_green,
			items.data.new_flux_red};
		priority if (!in_range) begin
			tk.op     = OP_SKIP;
			tk.shared = 1'b0;
		end else if (items.data.kind == KIND_INIT) begin
			tk.op     = OP_INIT;
			tk.shared = 1'b0;
		end else if (!sppm && !items.data.is_surface) begin
			tk.op = OP_PPM_CONST;
		end else if (!sppm && !shared) begin
			tk.op = OP_PPM_SURF;
		end else if (!sppm) begin
			tk.op = OP_PPM_SHARED;
		end else if (!items.data.is_surface) begin
			tk.op = OP_SPPM_CONST;
		end else begin
			tk.op = OP_SPPM_SURF;
		end
	end

	assign items.ready = cnt_q != CW'(QD);
	assign push        = items.valid && items.ready;
	assign q_valid     = cnt_q != '0;
	assign pop         = q_pop && q_valid;
	assign q_task      = fifo_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				fifo_q[wp_q] <= tk;
				wp_q         <= wp_q + PW'(1);
			end
			if (pop) begin
				rp_q <= rp_q + PW'(1);
			end
			cnt_q <= cnt_q + CW'(push) - CW'(pop);
		end
	end

endmodule

// ===== src/hpru_back.sv =====
// ----------------------------------------------------------------------------
// hpru_back
// Executes queued tasks: entry read, shrink, radiance terms, write back.
// ----------------------------------------------------------------------------
module hpru_back import hpru_pkg::*; #(
	parameter int HIT_POINTS = HIT_POINTS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       q_valid,
	input  task_t      q_task,
	output logic       q_pop,
	hpru_result_if.source results
);

	localparam int AW = (HIT_POINTS > 1) ? $clog2(HIT_POINTS) : 1;
	localparam int EW = $bits(entry_t);

	typedef enum logic [16:0] {
		B_IDLE = 17'h00001,
		B_READ = 17'h00002,
		B_LOAD = 17'h00004,
		B_SH_A = 17'h00008,
		B_SH_B = 17'h00010,
		B_SH_C = 17'h00020,
		B_SH_D = 17'h00040,
		B_SH_E = 17'h00080,
		B_SH_F = 17'h00100,
		B_FT_A = 17'h00200,
		B_FT_B = 17'h00400,
		B_FT_C = 17'h00800,
		B_FT_D = 17'h01000,
		B_FT_E = 17'h02000,
		B_WRITE = 17'h04000,
		B_DONE = 17'h08000,
		B_SPARE = 17'h10000
	} bstate_t;

	bstate_t          state_q;
	logic             wait_q;
	logic [1:0]       ch_q;
	task_t            tk_q;
	entry_t           ent_q;
	logic [63:0]      num_q;
	logic [63:0]      sden_q;
	logic [ALU_W-1:0] prod_q;
	logic [ALU_W-1:0] fden_q;
	logic [ALU_W-1:0] fnum_q;
	result_t          res_q;
	logic             res_valid_q;

	alu_req_t         alu_req;
	alu_rsp_t         alu_rsp;
	logic             arith;
	logic [AW-1:0]    addr;
	logic [EW-1:0]    ram_rdata;
	entry_t           e;
	logic [PT_W:0]    sum41;
	logic [R2_W-1:0]  r2sel;
	logic [CNT_W-1:0] weight;
	logic [CNT_W:0]   hits;
	logic [COL_W:0]   fsum;
	logic             is_sppm;
	logic             t_ok;
	logic [ALU_W-1:0] t_val;
	logic [CNT_W-1:0] chits_inc;
	logic [CNT_W-1:0] shits_inc;

	assign addr    = AW'(tk_q.index);
	assign e       = entry_t'(ram_rdata);
	assign is_sppm = tk_q.op == OP_SPPM_CONST || tk_q.op == OP_SPPM_SURF;
	assign sum41   = {1'b0, ent_q.photon_total} + (PT_W + 1)'(tk_q.m);
	assign r2sel   = tk_q.shared ? cfg.shared_r2 : ent_q.radius2;
	assign weight  = is_sppm ? ent_q.surf_hits : CNT_W'(1);
	assign hits    = (CNT_W + 1)'(ent_q.const_hits) + (CNT_W + 1)'(ent_q.surf_hits);
	assign fsum    = (COL_W + 1)'(ent_q.flux[ch_q]) + (COL_W + 1)'(tk_q.nf[ch_q]);
	assign t_ok    = (fnum_q == '0) || alu_rsp.done;
	assign t_val   = (fnum_q == '0) ? '0 : alu_rsp.res;
	assign chits_inc = (e.const_hits == '1) ? e.const_hits : e.const_hits + CNT_W'(1);
	assign shits_inc = (e.surf_hits == '1) ? e.surf_hits : e.surf_hits + CNT_W'(1);
	assign q_pop   = (state_q == B_IDLE) && q_valid;

	always_comb begin
		alu_req.op = ALU_MUL;
		alu_req.a  = '0;
		alu_req.b  = '0;
		arith      = 1'b1;
		unique case (state_q)
			B_SH_A: begin
				alu_req.a = ALU_W'(cfg.alpha);
				alu_req.b = ALU_W'(sum41);
			end
			B_SH_B: begin
				alu_req.a = ALU_W'(ent_q.photon_total);
				alu_req.b = ALU_W'(cfg.alpha);
			end
			B_SH_C: begin
				alu_req.a = ALU_W'(num_q);
				alu_req.b = ALU_W'(ent_q.radius2);
			end
			B_SH_D, B_SH_F: begin
				alu_req.op = ALU_DIV;
				alu_req.a  = prod_q;
				alu_req.b  = ALU_W'(sden_q);
			end
			B_SH_E: begin
				alu_req.a = ALU_W'(num_q);
				alu_req.b = ALU_W'(fsum);
			end
			B_FT_A: begin
				alu_req.a = ALU_W'(PI_Q32);
				alu_req.b = ALU_W'(r2sel);
			end
			B_FT_B: begin
				alu_req.a = prod_q;
				alu_req.b = ALU_W'(cfg.photons);
			end
			B_FT_C: begin
				alu_req.a = ALU_W'(ent_q.flux[ch_q]);
				alu_req.b = ALU_W'(weight);
			end
			B_FT_D: begin
				alu_req.op = ALU_DIV;
				alu_req.a  = fnum_q;
				alu_req.b  = fden_q;
				arith      = fnum_q != '0;
			end
			B_FT_E: begin
				alu_req.op = ALU_DIV;
				alu_req.a  = prod_q;
				alu_req.b  = ALU_W'(hits);
			end
			default: arith = 1'b0;
		endcase
		alu_req.start = arith && !wait_q;
	end

	hpru_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.rsp    (alu_rsp)
	);

	hpru_ram #(
		.WIDTH (EW),
		.DEPTH (HIT_POINTS)
	) u_ram (
		.clk   (clk),
		.we    (state_q == B_WRITE),
		.waddr (addr),
		.wdata (EW'(ent_q)),
		.raddr (addr),
		.rdata (ram_rdata)
	);

	assign results.valid = res_valid_q;
	assign results.data  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			wait_q      <= 1'b0;
			ch_q        <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (alu_req.start) begin
				wait_q <= 1'b1;
			end
			if (alu_rsp.done) begin
				wait_q <= 1'b0;
			end
			if (res_valid_q && results.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (q_valid) begin
						tk_q    <= q_task;
						state_q <= B_READ;
					end
				end
				B_READ: state_q <= B_LOAD;
				B_LOAD: begin
					ent_q <= e;
					unique case (tk_q.op)
						OP_SKIP: begin
							ent_q   <= '0;
							state_q <= B_DONE;
						end
						OP_INIT: begin
							ent_q         <= '0;
							ent_q.radius2 <= cfg.init_r2;
							state_q       <= B_WRITE;
						end
						OP_PPM_CONST: begin
							ent_q.last <= tk_q.tp;
							state_q    <= B_WRITE;
						end
						OP_PPM_SURF: begin
							state_q <= (tk_q.m != '0) ? B_SH_A : B_DONE;
						end
						OP_PPM_SHARED: begin
							if (tk_q.m != '0) begin
								ent_q.flux <= tk_q.nf;
								state_q    <= B_FT_A;
							end else begin
								ent_q.last <= '0;
								state_q    <= B_WRITE;
							end
						end
						OP_SPPM_CONST: begin
							for (int c = 0; c < 3; c++) begin
								ent_q.summed[c] <= sat40((PT_W + 1)'(e.summed[c]) +
									(PT_W + 1)'(tk_q.tp[c]));
							end
							ent_q.const_hits <= chits_inc;
							state_q          <= B_FT_A;
						end
						OP_SPPM_SURF: begin
							ent_q.surf_hits <= shits_inc;
							if (tk_q.m != '0 && tk_q.shared) begin
								ent_q.flux <= tk_q.nf;
								state_q    <= B_FT_A;
							end else if (tk_q.m != '0) begin
								state_q <= B_SH_A;
							end else begin
								state_q <= B_FT_A;
							end
						end
						default: state_q <= B_DONE;
					endcase
				end
				B_SH_A: begin
					if (alu_rsp.done) begin
						num_q   <= alu_rsp.res[63:0];
						state_q <= B_SH_B;
					end
				end
				B_SH_B: begin
					if (alu_rsp.done) begin
						sden_q  <= alu_rsp.res[63:0] + 64'({tk_q.m, 16'b0});
						state_q <= B_SH_C;
					end
				end
				B_SH_C: begin
					if (alu_rsp.done) begin
						prod_q  <= alu_rsp.res;
						state_q <= B_SH_D;
					end
				end
				B_SH_D: begin
					if (alu_rsp.done) begin
						ent_q.radius2      <= alu_rsp.res[R2_W-1:0];
						ent_q.photon_total <= sat40(sum41);
						ch_q               <= '0;
						state_q            <= B_SH_E;
					end
				end
				B_SH_E: begin
					if (alu_rsp.done) begin
						prod_q  <= alu_rsp.res;
						state_q <= B_SH_F;
					end
				end
				B_SH_F: begin
					if (alu_rsp.done) begin
						ent_q.flux[ch_q] <= sat32(alu_rsp.res);
						if (ch_q == 2'd2) begin
							state_q <= B_FT_A;
						end else begin
							ch_q    <= ch_q + 2'd1;
							state_q <= B_SH_E;
						end
					end
				end
				B_FT_A: begin
					if (alu_rsp.done) begin
						prod_q  <= alu_rsp.res;
						state_q <= B_FT_B;
					end
				end
				B_FT_B: begin
					if (alu_rsp.done) begin
						fden_q  <= alu_rsp.res;
						ch_q    <= '0;
						state_q <= B_FT_C;
					end
				end
				B_FT_C: begin
					if (alu_rsp.done) begin
						fnum_q  <= {alu_rsp.res[71:0], 56'b0};
						state_q <= B_FT_D;
					end
				end
				B_FT_D: begin
					if (t_ok) begin
						if (is_sppm && t_val != '1) begin
							prod_q  <= ALU_W'(ent_q.summed[ch_q]) + t_val;
							state_q <= B_FT_E;
						end else begin
							ent_q.last[ch_q] <= sat32(t_val);
							if (ch_q == 2'd2) begin
								state_q <= B_WRITE;
							end else begin
								ch_q    <= ch_q + 2'd1;
								state_q <= B_FT_C;
							end
						end
					end
				end
				B_FT_E: begin
					if (alu_rsp.done) begin
						ent_q.last[ch_q] <= sat32(alu_rsp.res);
						if (ch_q == 2'd2) begin
							state_q <= B_WRITE;
						end else begin
							ch_q    <= ch_q + 2'd1;
							state_q <= B_FT_C;
						end
					end
				end
				B_WRITE: state_q <= B_DONE;
				B_DONE: begin
					if (!res_valid_q || results.ready) begin
						res_q.radiance_red   <= ent_q.last[0];
						res_q.radiance_green <= ent_q.last[1];
						res_q.radiance_blue  <= ent_q.last[2];
						res_q.radius2_now    <= tk_q.shared ? cfg.shared_r2 : ent_q.radius2;
						res_valid_q          <= 1'b1;
						state_q              <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule

// ===== src/hit_point_radiance_update.sv =====
// ----------------------------------------------------------------------------
// hit_point_radiance_update
// Progressive photon mapping hit point table with radius and radiance update.
//
//   channel   dir   handshake        word
//   items     in    valid/ready      item_t: kind, entry, throughput, flux
//   results   out   valid/ready      result_t: radiance rgb, radius2_now
//   apb       in    psel/penable     64-bit config registers at 8*i
//
// Out-of-range, initialize and PPM constant words need no arithmetic; an SPPM
// surface word with shrink takes longest: every multiply and divide runs on
// one shared bit-serial unit, and a multiply takes longer the more bits its
// second operand has. A two-word queue takes new words while the back end
// works and a result waits in its output register.
// Reset clears control and config; table entries hold nothing until written.
// ----------------------------------------------------------------------------
module hit_point_radiance_update import hpru_pkg::*; #(
	parameter int HIT_POINTS = HIT_POINTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [CFG_DW-1:0] pwdata,
	output logic [CFG_DW-1:0] prdata,
	output logic              pready,
	hpru_item_if.sink         items,
	hpru_result_if.source     results
);

	cfg_t       cfg_q;
	logic       q_valid;
	task_t      q_task;
	logic       q_pop;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[CFG_AW-1:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode      <= MODE_RST;
			cfg_q.alpha     <= ALPHA_RST;
			cfg_q.photons   <= PHOTONS_RST;
			cfg_q.shared_r2 <= R2_RST;
			cfg_q.init_r2   <= R2_RST;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				REG_MODE:      cfg_q.mode      <= pwdata[MODE_W-1:0];
				REG_ALPHA:     cfg_q.alpha     <= pwdata[ALPHA_W-1:0];
				REG_PHOTONS:   cfg_q.photons   <= pwdata[PT_W-1:0];
				REG_SHARED_R2: cfg_q.shared_r2 <= pwdata[R2_W-1:0];
				REG_INIT_R2:   cfg_q.init_r2   <= pwdata[R2_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_MODE:      prdata = CFG_DW'(cfg_q.mode);
			REG_ALPHA:     prdata = CFG_DW'(cfg_q.alpha);
			REG_PHOTONS:   prdata = CFG_DW'(cfg_q.photons);
			REG_SHARED_R2: prdata = CFG_DW'(cfg_q.shared_r2);
			REG_INIT_R2:   prdata = CFG_DW'(cfg_q.init_r2);
			default:       prdata = '0;
		endcase
	end

	hpru_front #(
		.HIT_POINTS (HIT_POINTS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items),
		.mode    (cfg_q.mode),
		.q_valid (q_valid),
		.q_task  (q_task),
		.q_pop   (q_pop)
	);

	hpru_back #(
		.HIT_POINTS (HIT_POINTS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_valid (q_valid),
		.q_task  (q_task),
		.q_pop   (q_pop),
		.results (results)
	);

endmodule
